// ===== src/bpl_pkg.sv =====
package bpl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KIND_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int CNT_W = 7;
	localparam int ST_W = 2;

	localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] K_INS_BACK = 3'd1;
	localparam logic [KIND_W-1:0] K_INS_POS = 3'd2;
	localparam logic [KIND_W-1:0] K_REM_FIRST = 3'd3;
	localparam logic [KIND_W-1:0] K_REM_LAST = 3'd4;
	localparam logic [KIND_W-1:0] K_DUMP = 3'd5;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL = 2'd3;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INS_FRONT,
		OP_INS_BACK,
		OP_INS_POS,
		OP_REM_FIRST,
		OP_REM_LAST,
		OP_DUMP
	} op_t;

	typedef struct packed {
		op_t op;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
	} bpl_req_t;

	typedef enum logic {
		BK_RUN,
		BK_DUMP
	} bk_state_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_INSERT,
		SH_LEFT,
		SH_ROTATE
	} shift_t;

endpackage

// ===== src/bpl_in_if.sv =====
interface bpl_in_if;
	import bpl_pkg::*;

	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0] position;

	modport source (output valid, output kind, output value, output position, input ready);
	modport sink (input valid, input kind, input value, input position, output ready);

endinterface

// ===== src/bpl_out_if.sv =====
interface bpl_out_if;
	import bpl_pkg::*;

	logic valid;
	logic ready;
	logic [ST_W-1:0] status;
	logic [CNT_W-1:0] count;
	logic signed [VAL_W-1:0] element;
	logic last;

	modport source (output valid, output status, output count, output element, output last,
		input ready);
	modport sink (input valid, input status, input count, input element, input last,
		output ready);

endinterface

// ===== src/bpl_front.sv =====
module bpl_front (
	bpl_in_if.sink req,
	output logic push_valid,
	input logic push_ready,
	output bpl_pkg::bpl_req_t push_data
);
	import bpl_pkg::*;

	assign req.ready = push_ready;
	assign push_valid = req.valid;

	always_comb begin
		push_data.value = req.value;
		push_data.position = req.position;
		unique case (req.kind)
			K_INS_FRONT: push_data.op = OP_INS_FRONT;
			K_INS_BACK: push_data.op = OP_INS_BACK;
			K_INS_POS: push_data.op = OP_INS_POS;
			K_REM_FIRST: push_data.op = OP_REM_FIRST;
			K_REM_LAST: push_data.op = OP_REM_LAST;
			K_DUMP: push_data.op = OP_DUMP;
			default: push_data.op = OP_NOP;
		endcase
	end

endmodule

// ===== src/bpl_queue.sv =====
module bpl_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input bpl_pkg::bpl_req_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output bpl_pkg::bpl_req_t pop_data
);
	import bpl_pkg::*;

	localparam int DEPTH = 2;
	localparam int AW = $clog2(DEPTH);

	bpl_req_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] fill_q;
	logic push;
	logic pop;

	assign push_ready = fill_q != (AW+1)'(DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (AW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ===== src/bpl_back.sv =====
module bpl_back #(
	parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input bpl_pkg::bpl_req_t pop_data,
	bpl_out_if.source rsp
);
	import bpl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic signed [VAL_W-1:0] cells_q [CAPACITY];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] didx_q;
	logic [CW-1:0] didx_d;
	logic [CW-1:0] ins_idx;
	bk_state_t state_q;
	bk_state_t state_d;
	shift_t shift;

	logic out_free;
	logic emit;
	logic [ST_W-1:0] e_status;
	logic signed [VAL_W-1:0] e_element;
	logic e_last;

	logic out_valid_q;
	logic [ST_W-1:0] status_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [VAL_W-1:0] element_q;
	logic last_q;

	logic [PW-1:0] pos_x;
	logic [PW-1:0] lim_x;
	logic bad_pos;
	logic full;
	logic empty;
	logic dump_last;

	always_comb begin
		out_free = !out_valid_q || rsp.ready;
		pos_x = PW'(pop_data.position);
		lim_x = PW'(count_q) + PW'(1);
		bad_pos = (pos_x == '0) || (pos_x > lim_x);
		full = count_q == CW'(CAPACITY);
		empty = count_q == '0;
		dump_last = didx_q == (count_q - CW'(1));

		pop_ready = 1'b0;
		emit = 1'b0;
		e_status = ST_OK;
		e_element = '0;
		e_last = 1'b1;
		count_d = count_q;
		didx_d = didx_q;
		state_d = state_q;
		shift = SH_NONE;
		ins_idx = '0;

		unique case (state_q)
			BK_RUN: begin
				pop_ready = out_free;
				if (pop_valid && out_free) begin
					emit = 1'b1;
					unique case (pop_data.op)
						OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
							if (pop_data.op == OP_INS_POS && bad_pos) begin
								e_status = ST_BADPOS;
							end else if (full) begin
								e_status = ST_FULL;
							end else begin
								shift = SH_INSERT;
								count_d = count_q + CW'(1);
								priority case (pop_data.op)
									OP_INS_FRONT: ins_idx = '0;
									OP_INS_BACK: ins_idx = count_q;
									default: ins_idx = CW'(pop_data.position - POS_W'(1));
								endcase
							end
						end
						OP_REM_FIRST: begin
							if (empty) begin
								e_status = ST_EMPTY;
							end else begin
								shift = SH_LEFT;
								count_d = count_q - CW'(1);
							end
						end
						OP_REM_LAST: begin
							if (empty) begin
								e_status = ST_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						OP_DUMP: begin
							if (empty) begin
								e_status = ST_EMPTY;
							end else begin
								emit = 1'b0;
								state_d = BK_DUMP;
								didx_d = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_DUMP: begin
				if (out_free) begin
					emit = 1'b1;
					e_element = cells_q[0];
					e_last = dump_last;
					shift = SH_ROTATE;
					didx_d = didx_q + CW'(1);
					if (dump_last) begin
						state_d = BK_RUN;
					end
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	// one cell per entry, neighbors at fixed places
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] cell_prev;
		logic signed [VAL_W-1:0] cell_next;

		if (i == 0) begin : g_first
			assign cell_prev = cells_q[0];
		end else begin : g_mid
			assign cell_prev = cells_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_lastc
			assign cell_next = cells_q[i];
		end else begin : g_nextc
			assign cell_next = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			unique case (shift)
				SH_INSERT: begin
					if (CW'(i) == ins_idx) begin
						cells_q[i] <= pop_data.value;
					end else if (CW'(i) > ins_idx && CW'(i) <= count_q) begin
						cells_q[i] <= cell_prev;
					end
				end
				SH_LEFT: begin
					if (CW'(i + 1) < count_q) begin
						cells_q[i] <= cell_next;
					end
				end
				SH_ROTATE: begin
					if (CW'(i + 1) < count_q) begin
						cells_q[i] <= cell_next;
					end else if (CW'(i + 1) == count_q) begin
						cells_q[i] <= cells_q[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			count_q <= '0;
			didx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			didx_q <= didx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= e_status;
			cnt_q <= CNT_W'(count_d);
			element_q <= e_element;
			last_q <= e_last;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.count = cnt_q;
	assign rsp.element = element_q;
	assign rsp.last = last_q;

endmodule

// ===== src/bounded_positional_list_top.sv =====
// bounded positional list: ordered store of up to CAPACITY signed words
// req channel: one transaction per request (kind, value, position)
// rsp channel: status, count after the request, element and last flag
// inserts, removes and unused kinds answer with one transaction, element 0
// a dump answers with one transaction per stored word in order, last on
// the final one; a dump of an empty list answers once with empty status
// a front stage decodes each request into a two-entry queue; the back
// stage holds the words in a row of cells that shift in parallel
// a request passes through the queue and then the result register before
// rsp can take its result
// throughput: one insert or remove per cycle while rsp is not stalled; a
// dump holds the back stage until every word has gone out through the cell
// rotation, while the queue keeps taking up to two requests
// when rsp is stalled the result register holds and the back stage waits;
// req drops ready once the queue is full
// reset clears the count, the queue and the result register; the cells
// are not cleared and only entries below the count are ever read
module bounded_positional_list_top #(
	parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	bpl_in_if.sink req,
	bpl_out_if.source rsp
);
	import bpl_pkg::*;

	logic push_valid;
	logic push_ready;
	bpl_req_t push_data;
	logic pop_valid;
	logic pop_ready;
	bpl_req_t pop_data;

	bpl_front u_front (
		.req(req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	bpl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	bpl_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.rsp(rsp)
	);

endmodule

// ===== src/bpl_checker.sv =====
module bpl_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [bpl_pkg::ST_W-1:0] rsp_status,
	input logic [bpl_pkg::CNT_W-1:0] rsp_count,
	input logic signed [bpl_pkg::VAL_W-1:0] rsp_element,
	input logic rsp_last
);
	import bpl_pkg::*;

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("rsp valid during reset");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count)
			&& $stable(rsp_element) && $stable(rsp_last))
		else $error("stalled rsp changed");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_element == '0
			&& rsp_last)
		else $error("bad empty result");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_BADPOS || rsp_status == ST_FULL)
			|-> rsp_last && rsp_element == '0)
		else $error("bad error result");

	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == ST_OK)
		else $error("non-final result without ok status");

endmodule

bind bounded_positional_list_top bpl_checker u_bpl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rsp_count(rsp.count),
	.rsp_element(rsp.element),
	.rsp_last(rsp.last)
);
